### sv/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TMR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define TMR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TMR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define TMR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### sv/tmr_pkg.sv
package tmr_pkg;

    localparam int DEF_MAX_VERTICES = 1024;

    localparam int VERT_W  = 10;
    localparam int POS_W   = 32;
    localparam int VAL_W   = 64;
    localparam int DIFF_W  = 33;
    localparam int MUL_W   = 34;
    localparam int PROD_W  = 68;
    localparam int CROSS_W = 67;
    localparam int ACC_W   = 104;
    localparam int SRC_W   = 98;
    localparam int REM_W   = 66;
    localparam int QUO_W   = 88;
    localparam int CNT_W   = 7;

    localparam logic [CNT_W-1:0] SQRT_STEPS = 7'd49;
    localparam logic [CNT_W-1:0] DIV3_STEPS = 7'd22;
    localparam logic [CNT_W-1:0] INV_STEPS  = 7'd67;

    localparam logic [VAL_W-1:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [VAL_W-1:0] VAL_MIN = 64'h8000_0000_0000_0000;

    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_EDGE = 2'd1,
        MODE_TET  = 2'd2,
        MODE_READ = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_LEN  = 2'd0,
        KIND_VOL  = 2'd1,
        KIND_MASS = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        IF_SQRT = 2'd0,
        IF_DIV3 = 2'd1,
        IF_INV  = 2'd2
    } iter_func_t;

    typedef enum logic [3:0] {
        OP_CX0 = 4'd0,  OP_CX1 = 4'd1,
        OP_CY0 = 4'd2,  OP_CY1 = 4'd3,
        OP_CZ0 = 4'd4,  OP_CZ1 = 4'd5,
        OP_TXH = 4'd6,  OP_TXL = 4'd7,
        OP_TYH = 4'd8,  OP_TYL = 4'd9,
        OP_TZH = 4'd10, OP_TZL = 4'd11,
        OP_SQX = 4'd12, OP_SQY = 4'd13,
        OP_SQZ = 4'd14
    } mac_op_t;

    typedef enum logic {
        MSEL_INDEX  = 1'b0,
        MSEL_CORNER = 1'b1
    } msel_t;

    typedef struct packed {
        logic        latch;
        logic        load;
        logic        fetch;
        logic [2:0]  fidx;
        logic        mac_go;
        mac_op_t     mac_op;
        logic        iinit;
        logic        istep;
        iter_func_t  ifunc;
        logic        vol_set;
        logic        m_rd;
        logic        m_wr;
        logic        m_clr;
        msel_t       msel;
        logic [1:0]  corner;
        logic        emit;
        kind_t       ekind;
    } cmd_t;

    typedef struct packed {
        logic vpos_nz;
    } status_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] x;
        logic signed [DIFF_W-1:0] y;
        logic signed [DIFF_W-1:0] z;
    } dvec_t;

    function automatic logic [CNT_W-1:0] iter_steps(input iter_func_t f);
        logic [CNT_W-1:0] n;
        case (f)
            IF_SQRT: n = SQRT_STEPS;
            IF_DIV3: n = DIV3_STEPS;
            IF_INV:  n = INV_STEPS;
            default: n = SQRT_STEPS;
        endcase
        return n;
    endfunction

    // p - o per component, positions packed {x, y, z}
    function automatic dvec_t vdiff(input logic [3*POS_W-1:0] p,
                                    input logic [3*POS_W-1:0] o);
        dvec_t d;
        d.x = DIFF_W'(signed'(p[3*POS_W-1 -: POS_W])) - DIFF_W'(signed'(o[3*POS_W-1 -: POS_W]));
        d.y = DIFF_W'(signed'(p[2*POS_W-1 -: POS_W])) - DIFF_W'(signed'(o[2*POS_W-1 -: POS_W]));
        d.z = DIFF_W'(signed'(p[POS_W-1 -: POS_W])) - DIFF_W'(signed'(o[POS_W-1 -: POS_W]));
        return d;
    endfunction

endpackage

### sv/tmr_iter.sv
module tmr_iter (
    input  logic                       clk,
    input  logic                       init,
    input  logic                       step,
    input  tmr_pkg::iter_func_t        func,
    input  logic [tmr_pkg::SRC_W-1:0]  src_in,
    input  logic [62:0]                div_in,
    output logic [tmr_pkg::QUO_W-1:0]  q
);
    import tmr_pkg::*;

    iter_func_t       func_reg;
    logic [SRC_W-1:0] src_reg, src_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] q_reg, q_next;
    logic [62:0]      div_reg;

    logic [REM_W-1:0] remw, trial;
    logic             ge;
    logic [5:0]       cur, r3;
    logic [11:0]      prod;
    logic [3:0]       qd;

    always_comb
    begin
        remw  = '0;
        trial = '0;
        ge    = 1'b0;
        cur   = {rem_reg[1:0], src_reg[SRC_W-1 -: 4]};
        prod  = 12'(cur) * 12'd43;
        qd    = prod[10:7];
        r3    = cur - {1'b0, qd, 1'b0} - {2'b0, qd};
        rem_next = rem_reg;
        q_next   = q_reg;
        src_next = src_reg;
        case (func_reg)
            IF_SQRT:
            begin
                // one root bit per step from two radicand bits
                remw  = {rem_reg[REM_W-3:0], src_reg[SRC_W-1 -: 2]};
                trial = {q_reg[REM_W-3:0], 2'b01};
                ge    = remw >= trial;
                rem_next = ge ? remw - trial : remw;
                q_next   = {q_reg[QUO_W-2:0], ge};
                src_next = src_reg << 2;
            end
            IF_DIV3:
            begin
                // one hex digit of the quotient by three per step
                rem_next = REM_W'(r3);
                q_next   = {q_reg[QUO_W-5:0], qd};
                src_next = src_reg << 4;
            end
            IF_INV:
            begin
                remw  = {rem_reg[REM_W-2:0], src_reg[SRC_W-1]};
                ge    = remw >= REM_W'(div_reg);
                rem_next = ge ? remw - REM_W'(div_reg) : remw;
                q_next   = {q_reg[QUO_W-2:0], ge};
                src_next = src_reg << 1;
            end
            default:
            begin
                rem_next = rem_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (init)
        begin
            func_reg <= func;
            src_reg  <= src_in;
            rem_reg  <= '0;
            q_reg    <= '0;
            div_reg  <= div_in;
        end
        else if (step)
        begin
            src_reg <= src_next;
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign q = q_reg;

endmodule

### sv/tmr_ctrl.sv
module tmr_ctrl #(
    parameter int MAX_VERTICES = tmr_pkg::DEF_MAX_VERTICES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [1:0]                        mode,
    output logic                              busy,
    output tmr_pkg::cmd_t                     cmd,
    input  tmr_pkg::status_t                  status,
    output logic [$clog2(MAX_VERTICES)-1:0]   clr_addr
);
    import tmr_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);

    typedef enum logic [11:0] {
        ST_CLEAR = 12'b0000_0000_0001,
        ST_IDLE  = 12'b0000_0000_0010,
        ST_FETCH = 12'b0000_0000_0100,
        ST_MAC   = 12'b0000_0000_1000,
        ST_DRAIN = 12'b0000_0001_0000,
        ST_INIT  = 12'b0000_0010_0000,
        ST_ITER  = 12'b0000_0100_0000,
        ST_VOL   = 12'b0000_1000_0000,
        ST_MRD   = 12'b0001_0000_0000,
        ST_MWR   = 12'b0010_0000_0000,
        ST_RDM   = 12'b0100_0000_0000,
        ST_EMIT  = 12'b1000_0000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       mode_reg, mode_next;
    iter_func_t       func_reg, func_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic             is_edge;

    assign is_edge = (mode_reg == MODE_EDGE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        mode_next  = mode_reg;
        func_next  = func_reg;
        clr_next   = clr_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.m_clr = 1'b1;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == AW'(MAX_VERTICES - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.latch = 1'b1;
                    mode_next = mode;
                    cnt_next  = '0;
                    case (mode)
                        MODE_LOAD: cmd.load = 1'b1;
                        MODE_EDGE: state_next = ST_FETCH;
                        MODE_TET:  state_next = ST_FETCH;
                        MODE_READ: state_next = ST_RDM;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_FETCH:
            begin
                cmd.fetch = 1'b1;
                cmd.fidx  = cnt_reg[2:0];
                if (cnt_reg == (is_edge ? 7'd2 : 7'd4))
                begin
                    cnt_next   = '0;
                    state_next = ST_MAC;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_MAC:
            begin
                cmd.mac_go = 1'b1;
                cmd.mac_op = is_edge ? mac_op_t'(4'(OP_SQX) + cnt_reg[3:0])
                                     : mac_op_t'(cnt_reg[3:0]);
                if (cnt_reg == (is_edge ? 7'd2 : 7'd11))
                begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_DRAIN:
            begin
                func_next  = is_edge ? IF_SQRT : IF_DIV3;
                state_next = ST_INIT;
            end
            ST_INIT:
            begin
                cmd.iinit  = 1'b1;
                cmd.ifunc  = func_reg;
                cnt_next   = '0;
                state_next = ST_ITER;
            end
            ST_ITER:
            begin
                cmd.istep = 1'b1;
                cmd.ifunc = func_reg;
                if (cnt_reg == CNT_W'(iter_steps(func_reg) - 1'b1))
                begin
                    cnt_next = '0;
                    case (func_reg)
                        IF_SQRT: state_next = ST_EMIT;
                        IF_DIV3: state_next = ST_VOL;
                        IF_INV:  state_next = ST_MRD;
                        default: state_next = ST_EMIT;
                    endcase
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_VOL:
            begin
                cmd.vol_set = 1'b1;
                if (status.vpos_nz)
                begin
                    func_next  = IF_INV;
                    state_next = ST_INIT;
                end
                else
                    state_next = ST_EMIT;
            end
            ST_MRD:
            begin
                cmd.m_rd   = 1'b1;
                cmd.msel   = MSEL_CORNER;
                cmd.corner = cnt_reg[1:0];
                state_next = ST_MWR;
            end
            ST_MWR:
            begin
                cmd.m_wr   = 1'b1;
                cmd.msel   = MSEL_CORNER;
                cmd.corner = cnt_reg[1:0];
                if (cnt_reg == 7'd3)
                begin
                    cnt_next   = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_MRD;
                end
            end
            ST_RDM:
            begin
                cmd.m_rd   = 1'b1;
                cmd.msel   = MSEL_INDEX;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
                case (mode_reg)
                    MODE_EDGE: cmd.ekind = KIND_LEN;
                    MODE_TET:  cmd.ekind = KIND_VOL;
                    default:   cmd.ekind = KIND_MASS;
                endcase
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            mode_reg  <= '0;
            func_reg  <= IF_SQRT;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            mode_reg  <= mode_next;
            func_reg  <= func_next;
            clr_reg   <= clr_next;
        end
    end

    assign busy     = (state_reg != ST_IDLE);
    assign clr_addr = clr_reg;

endmodule

### sv/tmr_dp.sv
module tmr_dp #(
    parameter int MAX_VERTICES = tmr_pkg::DEF_MAX_VERTICES
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  tmr_pkg::cmd_t                         cmd,
    output tmr_pkg::status_t                      status,
    input  logic [$clog2(MAX_VERTICES)-1:0]       clr_addr,
    input  logic [tmr_pkg::VERT_W-1:0]            vert_index,
    input  logic signed [tmr_pkg::POS_W-1:0]      pos_x,
    input  logic signed [tmr_pkg::POS_W-1:0]      pos_y,
    input  logic signed [tmr_pkg::POS_W-1:0]      pos_z,
    input  logic [tmr_pkg::VERT_W-1:0]            vert_a,
    input  logic [tmr_pkg::VERT_W-1:0]            vert_b,
    input  logic [tmr_pkg::VERT_W-1:0]            vert_c,
    input  logic [tmr_pkg::VERT_W-1:0]            vert_d,
    output logic                                  done,
    output logic [1:0]                            kind,
    output logic signed [tmr_pkg::VAL_W-1:0]      value
);
    import tmr_pkg::*;

    localparam int AW  = $clog2(MAX_VERTICES);
    localparam int WRW = VERT_W + 17;

    // fold an index into the table range by binary compare-and-subtract
    function automatic logic [AW-1:0] wrap(input logic [VERT_W-1:0] v);
        logic [WRW-1:0] r;
        r = WRW'(v);
        for (int k = VERT_W - 1; k >= 0; k--)
        begin
            if (r >= (WRW'(MAX_VERTICES) << k))
                r = r - (WRW'(MAX_VERTICES) << k);
        end
        return r[AW-1:0];
    endfunction

    logic [AW-1:0] vi_reg, va_reg, vb_reg, vc_reg, vd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            vi_reg <= wrap(vert_index);
            va_reg <= wrap(vert_a);
            vb_reg <= wrap(vert_b);
            vc_reg <= wrap(vert_c);
            vd_reg <= wrap(vert_d);
        end
    end

    function automatic logic [AW-1:0] pick(input logic [1:0] s, input logic [AW-1:0] a,
                                           input logic [AW-1:0] b, input logic [AW-1:0] c,
                                           input logic [AW-1:0] d);
        logic [AW-1:0] r;
        case (s)
            2'd0:    r = a;
            2'd1:    r = b;
            2'd2:    r = c;
            default: r = d;
        endcase
        return r;
    endfunction

    // ---- vertex position table
    logic [3*POS_W-1:0] pos_mem [MAX_VERTICES];
    logic [3*POS_W-1:0] pos_q_reg;
    logic [AW-1:0]      pos_ra;

    assign pos_ra = pick(cmd.fidx[1:0], va_reg, vb_reg, vc_reg, vd_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            pos_mem[wrap(vert_index)] <= {pos_x, pos_y, pos_z};
        if (cmd.fetch)
            pos_q_reg <= pos_mem[pos_ra];
    end

    logic [3*POS_W-1:0] pa_reg;
    dvec_t              e1_reg, e2_reg, e3_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.fetch)
        begin
            case (cmd.fidx)
                3'd1:    pa_reg <= pos_q_reg;
                3'd2:    e1_reg <= vdiff(pos_q_reg, pa_reg);
                3'd3:    e2_reg <= vdiff(pos_q_reg, pa_reg);
                3'd4:    e3_reg <= vdiff(pos_q_reg, pa_reg);
                default: pa_reg <= pa_reg;
            endcase
        end
    end

    // ---- multiply-accumulate
    logic signed [CROSS_W-1:0] cx_reg, cy_reg, cz_reg;
    logic signed [MUL_W-1:0]   opa, opb;
    logic signed [PROD_W-1:0]  p_reg;
    mac_op_t                   pop_reg;
    logic                      pv_reg;
    logic signed [ACC_W-1:0]   acc_reg, acc_next, pext, base;
    logic                      op_clr, op_sub, op_hi;

    always_comb
    begin
        case (cmd.mac_op)
            OP_CX0:  begin opa = MUL_W'(e1_reg.y); opb = MUL_W'(e2_reg.z); end
            OP_CX1:  begin opa = MUL_W'(e1_reg.z); opb = MUL_W'(e2_reg.y); end
            OP_CY0:  begin opa = MUL_W'(e1_reg.z); opb = MUL_W'(e2_reg.x); end
            OP_CY1:  begin opa = MUL_W'(e1_reg.x); opb = MUL_W'(e2_reg.z); end
            OP_CZ0:  begin opa = MUL_W'(e1_reg.x); opb = MUL_W'(e2_reg.y); end
            OP_CZ1:  begin opa = MUL_W'(e1_reg.y); opb = MUL_W'(e2_reg.x); end
            OP_TXH:  begin opa = signed'(cx_reg[CROSS_W-1:DIFF_W]); opb = MUL_W'(e3_reg.x); end
            OP_TXL:  begin opa = signed'({1'b0, cx_reg[DIFF_W-1:0]}); opb = MUL_W'(e3_reg.x); end
            OP_TYH:  begin opa = signed'(cy_reg[CROSS_W-1:DIFF_W]); opb = MUL_W'(e3_reg.y); end
            OP_TYL:  begin opa = signed'({1'b0, cy_reg[DIFF_W-1:0]}); opb = MUL_W'(e3_reg.y); end
            OP_TZH:  begin opa = signed'(cz_reg[CROSS_W-1:DIFF_W]); opb = MUL_W'(e3_reg.z); end
            OP_TZL:  begin opa = signed'({1'b0, cz_reg[DIFF_W-1:0]}); opb = MUL_W'(e3_reg.z); end
            OP_SQX:  begin opa = MUL_W'(e1_reg.x); opb = MUL_W'(e1_reg.x); end
            OP_SQY:  begin opa = MUL_W'(e1_reg.y); opb = MUL_W'(e1_reg.y); end
            OP_SQZ:  begin opa = MUL_W'(e1_reg.z); opb = MUL_W'(e1_reg.z); end
            default: begin opa = '0; opb = '0; end
        endcase
    end

    always_comb
    begin
        op_clr = (pop_reg == OP_CX0) || (pop_reg == OP_CY0) || (pop_reg == OP_CZ0) ||
                 (pop_reg == OP_TXH) || (pop_reg == OP_SQX);
        op_sub = (pop_reg == OP_CX1) || (pop_reg == OP_CY1) || (pop_reg == OP_CZ1);
        op_hi  = (pop_reg == OP_TXH) || (pop_reg == OP_TYH) || (pop_reg == OP_TZH);
        pext   = ACC_W'(p_reg);
        if (op_hi)
            pext = pext <<< DIFF_W;
        base     = op_clr ? '0 : acc_reg;
        acc_next = op_sub ? base - pext : base + pext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= 1'b0;
        else
            pv_reg <= cmd.mac_go;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mac_go)
        begin
            p_reg   <= opa * opb;
            pop_reg <= cmd.mac_op;
        end
        if (pv_reg)
        begin
            acc_reg <= acc_next;
            if (pop_reg == OP_CX1) cx_reg <= acc_next[CROSS_W-1:0];
            if (pop_reg == OP_CY1) cy_reg <= acc_next[CROSS_W-1:0];
            if (pop_reg == OP_CZ1) cz_reg <= acc_next[CROSS_W-1:0];
        end
    end

    // ---- iterative unit: root, divide by three, reciprocal
    logic [ACC_W-1:0]  mag;
    logic [SRC_W-1:0]  src_in;
    logic [QUO_W-1:0]  iq;
    logic [VAL_W-1:0]  vol_reg;
    logic              acc_neg;

    assign acc_neg = acc_reg[ACC_W-1];
    assign mag     = acc_neg ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);

    always_comb
    begin
        case (cmd.ifunc)
            IF_SQRT: src_in = {acc_reg[65:0], 32'b0};
            IF_DIV3: src_in = {2'b0, mag[ACC_W-2:17], 10'b0};
            IF_INV:  src_in = {1'b1, {(SRC_W-1){1'b0}}};
            default: src_in = '0;
        endcase
    end

    tmr_iter u_iter (
        .clk    (clk),
        .init   (cmd.iinit),
        .step   (cmd.istep),
        .func   (cmd.ifunc),
        .src_in (src_in),
        .div_in (vol_reg[62:0]),
        .q      (iq)
    );

    // ---- volume from the quotient, with saturation
    logic [VAL_W-1:0] posv, negv, volv;
    logic             negbig;

    always_comb
    begin
        posv   = (iq[QUO_W-1:63] != '0) ? VAL_MAX : {1'b0, iq[62:0]};
        negbig = (iq[QUO_W-1:64] != '0) || (iq[63] && (iq[62:0] != '0));
        negv   = negbig ? VAL_MIN : (64'd0 - iq[63:0]);
        volv   = acc_neg ? negv : posv;
        status.vpos_nz = !acc_neg && (iq != '0);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.vol_set)
            vol_reg <= volv;
    end

    // ---- inverse mass table
    logic [VAL_W-1:0] mass_mem [MAX_VERTICES];
    logic [VAL_W-1:0] mq_reg, inc, wd, sat;
    logic [VAL_W:0]   sum;
    logic [AW-1:0]    corner_addr, ra, wa;
    logic             we;

    assign corner_addr = pick(cmd.corner, va_reg, vb_reg, vc_reg, vd_reg);
    assign ra  = (cmd.msel == MSEL_CORNER) ? corner_addr : vi_reg;
    assign inc = (vol_reg[62:0] <= 63'd8) ? VAL_MAX : {1'b0, iq[62:0]};
    assign sum = {1'b0, mq_reg} + {1'b0, inc};
    assign sat = (sum > {1'b0, VAL_MAX}) ? VAL_MAX : sum[VAL_W-1:0];

    always_comb
    begin
        we = cmd.m_clr || cmd.load || cmd.m_wr;
        wd = '0;
        wa = clr_addr;
        if (cmd.load)
            wa = wrap(vert_index);
        else if (cmd.m_wr)
        begin
            wa = corner_addr;
            wd = sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mass_mem[wa] <= wd;
        if (cmd.m_rd)
            mq_reg <= mass_mem[ra];
    end

    // ---- result register
    logic                    done_reg;
    logic [1:0]              kind_reg;
    logic signed [VAL_W-1:0] value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.emit;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            kind_reg <= cmd.ekind;
            case (cmd.ekind)
                KIND_LEN:  value_reg <= {15'b0, iq[48:0]};
                KIND_VOL:  value_reg <= vol_reg;
                KIND_MASS: value_reg <= mq_reg;
                default:   value_reg <= '0;
            endcase
        end
    end

    assign done  = done_reg;
    assign kind  = kind_reg;
    assign value = value_reg;

endmodule

### sv/tet_mesh_rest_state_init.sv
// Rest-state precompute for a tetrahedral soft body. Pulse start with busy low
// to hand in an item; the block takes at most one item at a time. A load
// (mode 0) completes in its accept cycle and busy stays low. Every other item
// raises busy, and its single result shows on kind/value, marked by done for
// exactly one cycle; the receiver cannot stall, so capture it then. An edge
// item runs a 49-step bit-serial square root; a tet item runs a 22-step
// divide by three and, only when its volume is positive, a 67-step
// reciprocal, then a read-modify-write of the mass table for each corner.
// After reset the inverse-mass table is swept to zero, one entry a cycle,
// with busy high. Vertex indices wrap modulo MAX_VERTICES.
// Reading a position that was never loaded returns garbage.
`include "assert_macros.svh"

module tet_mesh_rest_state_init #(
    parameter int MAX_VERTICES = tmr_pkg::DEF_MAX_VERTICES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        mode,
    input  logic [tmr_pkg::VERT_W-1:0]        vert_index,
    input  logic signed [tmr_pkg::POS_W-1:0]  pos_x,
    input  logic signed [tmr_pkg::POS_W-1:0]  pos_y,
    input  logic signed [tmr_pkg::POS_W-1:0]  pos_z,
    input  logic [tmr_pkg::VERT_W-1:0]        vert_a,
    input  logic [tmr_pkg::VERT_W-1:0]        vert_b,
    input  logic [tmr_pkg::VERT_W-1:0]        vert_c,
    input  logic [tmr_pkg::VERT_W-1:0]        vert_d,
    output logic                              done,
    output logic [1:0]                        kind,
    output logic signed [tmr_pkg::VAL_W-1:0]  value
);
    import tmr_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);

    cmd_t          cmd;
    status_t       status;
    logic [AW-1:0] clr_addr;

    // sequencer: clearing sweep, fetch, MAC program, iterations, mass update
    tmr_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .mode     (mode),
        .busy     (busy),
        .cmd      (cmd),
        .status   (status),
        .clr_addr (clr_addr)
    );

    // tables, shared multiplier, iterative unit and result register
    tmr_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .clr_addr   (clr_addr),
        .vert_index (vert_index),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .vert_a     (vert_a),
        .vert_b     (vert_b),
        .vert_c     (vert_c),
        .vert_d     (vert_d),
        .done       (done),
        .kind       (kind),
        .value      (value)
    );

    // a load finishes in its accept cycle
    `TMR_ASSERT_NXT(a_load_free, clk, rst_n, start && !busy && (mode == MODE_LOAD), !busy, "load held busy")
    // results never come back to back
    `TMR_ASSERT_NXT(a_done_single, clk, rst_n, done, !done, "double result strobe")
    // inverse mass saturates at the top and never goes negative
    `TMR_ASSERT_IMP(a_mass_pos, clk, rst_n, done && (kind == KIND_MASS), !value[63], "negative mass")
    // a length fits the root width
    `TMR_ASSERT_IMP(a_len_width, clk, rst_n, done && (kind == KIND_LEN), value[63:49] == '0, "length too wide")

endmodule
